FILE: rtl/utf8_stream_decoder_assert.svh
// Assertion macros for the stream decoder.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define U8SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define U8SD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define U8SD_ASSERT(lbl, prop, msg)
`define U8SD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/utf8sd_pkg.sv
package utf8sd_pkg;

  localparam int unsigned CpW   = 31;
  localparam int unsigned MinW  = 27;
  localparam int unsigned CntW  = 13;
  localparam int unsigned PendW = 3;

  localparam logic [CpW-1:0]  ReplChar     = 31'h0000_FFFD;
  localparam logic [CntW-1:0] LimitDefault = 13'h1000;

  localparam logic [7:0] ContFirst = 8'h80;
  localparam logic [7:0] LeadTwo   = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour  = 8'hF0;
  localparam logic [7:0] LeadFive  = 8'hF8;
  localparam logic [7:0] LeadSix   = 8'hFC;
  localparam logic [7:0] BadFirst  = 8'hFE;

  localparam logic [MinW-1:0] MinTwo   = 27'h000_0080;
  localparam logic [MinW-1:0] MinThree = 27'h000_0800;
  localparam logic [MinW-1:0] MinFour  = 27'h001_0000;
  localparam logic [MinW-1:0] MinFive  = 27'h020_0000;
  localparam logic [MinW-1:0] MinSix   = 27'h400_0000;

  typedef struct packed {
    logic             emit;
    logic [CpW-1:0]   cp;
    logic [PendW-1:0] pend;
    logic [CpW-1:0]   pv;
    logic [MinW-1:0]  minv;
  } start_t;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           last;
  } result_t;

  function automatic start_t start_char(logic [7:0] b);
    start_t s;
    s = '0;
    case (b) inside
      [8'h00:ContFirst - 8'd1]: begin
        s.emit = 1'b1;
        s.cp   = CpW'(b);
      end
      [ContFirst:LeadTwo - 8'd1]: begin
        s.emit = 1'b1;
        s.cp   = ReplChar;
      end
      [LeadTwo:LeadThree - 8'd1]: begin
        s.pend = 3'd1;
        s.pv   = CpW'(b[4:0]);
        s.minv = MinTwo;
      end
      [LeadThree:LeadFour - 8'd1]: begin
        s.pend = 3'd2;
        s.pv   = CpW'(b[3:0]);
        s.minv = MinThree;
      end
      [LeadFour:LeadFive - 8'd1]: begin
        s.pend = 3'd3;
        s.pv   = CpW'(b[2:0]);
        s.minv = MinFour;
      end
      [LeadFive:LeadSix - 8'd1]: begin
        s.pend = 3'd4;
        s.pv   = CpW'(b[1:0]);
        s.minv = MinFive;
      end
      [LeadSix:BadFirst - 8'd1]: begin
        s.pend = 3'd5;
        s.pv   = CpW'(b[0]);
        s.minv = MinSix;
      end
      default: begin
        s.emit = 1'b1;
        s.cp   = ReplChar;
      end
    endcase
    return s;
  endfunction

  function automatic logic [CpW-1:0] check_min(logic [CpW-1:0] v, logic [MinW-1:0] m);
    return (v < CpW'(m)) ? ReplChar : v;
  endfunction

endpackage

FILE: rtl/utf8_stream_decoder.sv
// Each input transfer writes its results into the registered result queue, which drives the output.
// Up to 1 byte per cycle, while the result queue has room for two results; a byte with
// two results gives them one at a time through the single read port of the 4-entry result queue.
// Reset (rst_ni low, asynchronous): pending character, string count and queue
// clear; char_limit returns to 4096.
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder
  import utf8sd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CntW-1:0] cfg_char_limit_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      text_byte_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CpW-1:0]  code_point_o,
  output logic            last_in_run_o
);

  localparam int unsigned Depth  = 4;
  localparam int unsigned PtrW   = $clog2(Depth);
  localparam int unsigned FillW  = $clog2(Depth + 1);

  logic [CntW-1:0]  limit_q;
  logic [PendW-1:0] pend_q, pend_d;
  logic [CpW-1:0]   pv_q, pv_d;
  logic [MinW-1:0]  min_q, min_d;
  logic [CntW-1:0]  count_q, count_d;

  result_t          fifo_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q, fill_d;

  logic             in_fire, out_fire;
  logic             emit_a, emit_b;
  logic [CpW-1:0]   cp_a, cp_b;
  logic [CpW-1:0]   pv_shift;
  logic [CntW-1:0]  count_inc;
  start_t           st;
  result_t          res0, res1;
  logic             push0, push1;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = fill_q <= FillW'(Depth - 2);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = fill_q != '0;
  assign out_fire    = out_valid_o && out_ready_i;

  assign st        = start_char(text_byte_i);
  assign pv_shift  = {pv_q[CpW-7:0], text_byte_i[5:0]};
  assign count_inc = count_q + CntW'(1);

  always_comb begin
    emit_a = 1'b0;
    emit_b = 1'b0;
    cp_a   = check_min(pv_q, min_q);
    cp_b   = st.cp;
    pend_d = pend_q;
    pv_d   = pv_q;
    min_d  = min_q;
    if (text_byte_i == 8'h00) begin
      emit_a = (pend_q != '0) && (count_q < limit_q);
      pend_d = '0;
      pv_d   = '0;
      min_d  = '0;
    end else if (count_q >= limit_q) begin
      emit_a = 1'b0;
    end else if (pend_q != '0) begin
      if (text_byte_i[7:6] == 2'b10) begin
        pend_d = pend_q - PendW'(1);
        pv_d   = pv_shift;
        if (pend_q == PendW'(1)) begin
          emit_a = 1'b1;
          cp_a   = check_min(pv_shift, min_q);
          pv_d   = '0;
          min_d  = '0;
        end
      end else begin
        emit_a = 1'b1;
        pend_d = '0;
        pv_d   = '0;
        min_d  = '0;
        if (count_inc < limit_q) begin
          emit_b = st.emit;
          pend_d = st.pend;
          pv_d   = st.pv;
          min_d  = st.minv;
        end
      end
    end else begin
      emit_b = st.emit;
      pend_d = st.pend;
      pv_d   = st.pv;
      min_d  = st.minv;
    end
    if (text_byte_i == 8'h00) begin
      count_d = '0;
    end else begin
      count_d = count_q + CntW'(emit_a) + CntW'(emit_b);
    end
  end

  assign res0.cp   = emit_a ? cp_a : cp_b;
  assign res0.last = !(emit_a && emit_b);
  assign res1.cp   = cp_b;
  assign res1.last = 1'b1;
  assign push0     = in_fire && (emit_a || emit_b);
  assign push1     = in_fire && emit_a && emit_b;
  assign fill_d    = fill_q + FillW'(push0) + FillW'(push1) - FillW'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LimitDefault;
      pend_q   <= '0;
      pv_q     <= '0;
      min_q    <= '0;
      count_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_char_limit_i;
      end
      if (in_fire) begin
        pend_q  <= pend_d;
        pv_q    <= pv_d;
        min_q   <= min_d;
        count_q <= count_d;
      end
      wr_ptr_q <= wr_ptr_q + PtrW'(push0) + PtrW'(push1);
      rd_ptr_q <= rd_ptr_q + PtrW'(out_fire);
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (push1) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  assign code_point_o  = fifo_q[rd_ptr_q].cp;
  assign last_in_run_o = fifo_q[rd_ptr_q].last;

  `U8SD_ASSERT(a_fill_bound, fill_q <= FillW'(Depth), "result queue overfilled")
  `U8SD_ASSERT(a_room_for_two, in_ready_o |-> (fill_q <= FillW'(Depth - 2)), "no room for two results")
  `U8SD_ASSERT(a_pend_range, pend_q <= PendW'(5), "pending count out of range")
  `U8SD_ASSERT(a_push_shows, push0 |=> out_valid_o, "result transfer lost")
  `U8SD_ASSERT(a_last_on_single, (push0 && !push1) |-> res0.last, "single result not marked last")

endmodule
